// ----- rtl/core/arp_pkg.sv -----
`default_nettype none

package arp_pkg;

  // Field widths of the addresses carried on both channels.
  localparam int unsigned IP_W  = 32;
  localparam int unsigned MAC_W = 48;

  // Default number of cache entries.
  localparam int unsigned CACHE_ENTRIES_DEF = 16;

  // Result kinds on the master-side tuser.
  localparam logic [1:0] KIND_HIT     = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_REPLY   = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_OWN_IP  = 1'b0;
  localparam logic CFG_OWN_MAC = 1'b1;

  // Broadcast hardware address used as the target of a request.
  localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

  // Answer of the cache to one lookup.
  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] mac;
  } arp_lookup_t;

endpackage

`default_nettype wire

// ----- rtl/core/arp_cache_responder.sv -----
`default_nettype none

// ARP cache and responder for one IPv4 host.
// The slave stream carries one word per lookup or received ARP packet; tuser
// says which (op) and whether a received packet is a reply. A lookup always
// yields one master word: the cached MAC on a hit, or a broadcast request on a
// miss. A received packet writes the sender into the cache and yields a reply
// word only when it is a request for this host's address; otherwise nothing.
// The configuration channel writes own_ip (index 0) and own_mac (index 1); it
// is always ready and must only be used while the block is idle.
// A word that is accepted is registered in the input register, searched by the tag
// compare there, and its result is then registered in the result register. One word
// per cycle is sustained while no stalled result blocks the input; the input register
// and the result register let a new word in while a finished result waits.
// When the receiver stalls, the result register holds; a word that produces
// a result then waits in the input register and tready drops. Words that
// produce no result still pass. Reset clears the cache, the replacement
// pointer and the valid bits of both registers, and sets own_ip and own_mac to zero.
module arp_cache_responder #(
  parameter int unsigned CACHE_ENTRIES = arp_pkg::CACHE_ENTRIES_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Slave side. tdata: query_ip, rx_sender_ip, rx_sender_mac, rx_target_ip.
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [143:0]              s_axis_tdata,
  // tuser: op, rx_is_reply.
  input  wire logic [1:0]                s_axis_tuser,
  // Master side. tdata: out_sender_ip, out_sender_mac, out_target_ip, out_target_mac.
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [159:0]                   m_axis_tdata,
  // tuser: out_kind.
  output logic [1:0]                     m_axis_tuser,
  // Configuration write channel.
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic                      cfg_index_i,
  input  wire logic [arp_pkg::MAC_W-1:0] cfg_data_i
);
  import arp_pkg::*;

  logic [IP_W-1:0]  own_ip_q;
  logic [MAC_W-1:0] own_mac_q;

  // Input register.
  logic             s1_valid_q, s1_valid_d;
  logic             s1_op_q;
  logic             s1_is_reply_q;
  logic [IP_W-1:0]  s1_query_ip_q;
  logic [IP_W-1:0]  s1_sender_ip_q;
  logic [MAC_W-1:0] s1_sender_mac_q;
  logic [IP_W-1:0]  s1_target_ip_q;

  // Result register.
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_kind_q, out_kind_d;
  logic [IP_W-1:0]  out_sip_q, out_tip_q, out_tip_d;
  logic [MAC_W-1:0] out_smac_q, out_tmac_q, out_tmac_d;

  logic             in_accept;
  logic             s1_emit;
  logic             s1_adv;
  logic             out_load;
  logic [IP_W-1:0]  lookup_ip;
  arp_lookup_t      lookup;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q  <= '0;
      own_mac_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OWN_IP:  own_ip_q  <= cfg_data_i[IP_W-1:0];
        CFG_OWN_MAC: own_mac_q <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // Stage control: a word leaves the input register when it yields no result or its result has room.
  assign s1_emit = !s1_op_q || (!s1_is_reply_q && (s1_target_ip_q == own_ip_q));
  assign s1_adv  = s1_valid_q && (!s1_emit || !out_valid_q || m_axis_tready);
  assign out_load = s1_adv && s1_emit;

  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign s1_valid_d  = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q         <= s_axis_tuser[0];
      s1_is_reply_q   <= s_axis_tuser[1];
      s1_query_ip_q   <= s_axis_tdata[31:0];
      s1_sender_ip_q  <= s_axis_tdata[63:32];
      s1_sender_mac_q <= s_axis_tdata[111:64];
      s1_target_ip_q  <= s_axis_tdata[143:112];
    end
  end

  // The cache is searched with the query address or the sender address.
  assign lookup_ip = s1_op_q ? s1_sender_ip_q : s1_query_ip_q;

  arp_neighbor_table #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_cache (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lookup_ip_i (lookup_ip),
    .lookup_o    (lookup),
    .wr_en_i     (s1_adv && s1_op_q),
    .wr_mac_i    (s1_sender_mac_q)
  );

  // Result word: hit answer, broadcast request, or unicast reply.
  always_comb begin
    if (!s1_op_q) begin
      out_kind_d = lookup.hit ? KIND_HIT : KIND_REQUEST;
      out_tip_d  = s1_query_ip_q;
      out_tmac_d = lookup.hit ? lookup.mac : BCAST_MAC;
    end else begin
      out_kind_d = KIND_REPLY;
      out_tip_d  = s1_sender_ip_q;
      out_tmac_d = s1_sender_mac_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_sip_q  <= own_ip_q;
      out_smac_q <= own_mac_q;
      out_tip_q  <= out_tip_d;
      out_tmac_q <= out_tmac_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {out_tmac_q, out_tip_q, out_smac_q, out_sip_q};

`ifndef SYNTHESIS
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == KIND_HIT || m_axis_tuser == KIND_REQUEST ||
                       m_axis_tuser == KIND_REPLY))
    else $error("result kind out of range");

  a_request_bcast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_REQUEST) |-> (out_tmac_q == BCAST_MAC))
    else $error("request word without broadcast target");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid_q && out_valid_q && s1_emit && !m_axis_tready))
    else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/arp_cache.sv -----
`default_nettype none

module arp_neighbor_table #(
  parameter int unsigned CACHE_ENTRIES = arp_pkg::CACHE_ENTRIES_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [arp_pkg::IP_W-1:0]   lookup_ip_i,
  output arp_pkg::arp_lookup_t            lookup_o,
  input  wire logic                       wr_en_i,
  input  wire logic [arp_pkg::MAC_W-1:0]  wr_mac_i
);
  import arp_pkg::*;

  localparam int unsigned IdxW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CACHE_ENTRIES - 1);

  logic [CACHE_ENTRIES-1:0] valid_q;
  logic [CACHE_ENTRIES-1:0] valid_d;
  logic [IP_W-1:0]          ip_q  [CACHE_ENTRIES];
  logic [MAC_W-1:0]         mac_q [CACHE_ENTRIES];
  logic [IdxW-1:0]          ptr_q;
  logic [IdxW-1:0]          ptr_d;

  logic [CACHE_ENTRIES-1:0] match;
  logic [IdxW-1:0]          hit_idx;
  logic [IdxW-1:0]          free_idx;
  logic                     any_free;
  logic [IdxW-1:0]          slot;

  // Parallel tag compare; an address is held at most once, so at most one match bit is set.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      match[i] = valid_q[i] && (ip_q[i] == lookup_ip_i);
      if (match[i]) begin
        hit_idx = IdxW'(i);
      end
    end
  end

  // Lowest-numbered free entry: scan downward so the lowest one wins.
  always_comb begin
    free_idx = '0;
    for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IdxW'(i);
      end
    end
  end

  assign any_free = ~&valid_q;

  assign lookup_o.hit = |match;
  assign lookup_o.mac = mac_q[hit_idx];

  // Slot choice: existing entry, else a free one, else round-robin replacement.
  always_comb begin
    ptr_d   = ptr_q;
    valid_d = valid_q;
    priority if (lookup_o.hit) begin
      slot = hit_idx;
    end else if (any_free) begin
      slot = free_idx;
    end else begin
      slot = ptr_q;
      if (wr_en_i) begin
        ptr_d = (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;
      end
    end
    if (wr_en_i) begin
      valid_d[slot] = 1'b1;
    end
  end

  // Control state of the cache.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ptr_q   <= ptr_d;
    end
  end

  // Entry storage; contents are only read through a valid match.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ip_q[slot]  <= lookup_ip_i;
      mac_q[slot] <= wr_mac_i;
    end
  end

`ifndef SYNTHESIS
  a_match_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("cache holds one address in more than one entry");

  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |=> valid_q[$past(slot)])
    else $error("written entry is not valid afterwards");

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= LastIdx)
    else $error("replacement pointer out of range");
`endif

endmodule

`default_nettype wire
